// ----- hdl/yuv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Types and constants for the 4:2:0 2x2 block to RGB888 converter
// ----------------------------------------------------------------------------
`default_nettype none

package yuv2rgb_pkg;

  localparam int SAMPLE_W = 8;
  localparam int LUMA_W   = 17;
  localparam int OFFS_W   = 9;
  localparam int TERM_W   = 18;
  localparam int SUM_W    = 19;

  localparam logic [SAMPLE_W-1:0] SAMPLE_LOW  = 8'd16;
  localparam logic [SAMPLE_W-1:0] SAMPLE_HIGH = 8'd240;
  localparam logic signed [OFFS_W-1:0] CHROMA_ZERO = 9'sd128;

  localparam logic [LUMA_W-1:0] LUMA_GAIN = 17'd298;
  localparam logic signed [TERM_W-1:0] RED_FROM_CR   = 18'sd408;
  localparam logic signed [TERM_W-1:0] GREEN_FROM_CR = -18'sd208;
  localparam logic signed [TERM_W-1:0] GREEN_FROM_CB = -18'sd100;
  localparam logic signed [TERM_W-1:0] BLUE_FROM_CB  = 18'sd517;

  localparam logic [SAMPLE_W-1:0] CHANNEL_MAX = 8'd255;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma_top_left;
    logic [SAMPLE_W-1:0] luma_top_right;
    logic [SAMPLE_W-1:0] luma_bottom_left;
    logic [SAMPLE_W-1:0] luma_bottom_right;
    logic [SAMPLE_W-1:0] chroma_blue;
    logic [SAMPLE_W-1:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_top_left;
    logic [SAMPLE_W-1:0] green_top_left;
    logic [SAMPLE_W-1:0] blue_top_left;
    logic [SAMPLE_W-1:0] red_top_right;
    logic [SAMPLE_W-1:0] green_top_right;
    logic [SAMPLE_W-1:0] blue_top_right;
    logic [SAMPLE_W-1:0] red_bottom_left;
    logic [SAMPLE_W-1:0] green_bottom_left;
    logic [SAMPLE_W-1:0] blue_bottom_left;
    logic [SAMPLE_W-1:0] red_bottom_right;
    logic [SAMPLE_W-1:0] green_bottom_right;
    logic [SAMPLE_W-1:0] blue_bottom_right;
  } out_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] red;
    logic signed [TERM_W-1:0] green;
    logic signed [TERM_W-1:0] blue;
  } chroma_terms_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pixel_t;

endpackage

`default_nettype wire

// ----- hdl/yuv2rgb_chroma.sv -----
// ----------------------------------------------------------------------------
// yuv2rgb_chroma
// Clamps the shared Cb and Cr samples and forms the per-channel chroma terms
// ----------------------------------------------------------------------------
`default_nettype none

module yuv2rgb_chroma (
  input  wire logic [7:0]                 chroma_blue,
  input  wire logic [7:0]                 chroma_red,
  output yuv2rgb_pkg::chroma_terms_t      terms
);
  import yuv2rgb_pkg::*;

  logic [SAMPLE_W-1:0]      cb_clamp;
  logic [SAMPLE_W-1:0]      cr_clamp;
  logic signed [OFFS_W-1:0] cb_offs;
  logic signed [OFFS_W-1:0] cr_offs;
  logic signed [TERM_W-1:0] cb_ext;
  logic signed [TERM_W-1:0] cr_ext;

  always_comb begin
    priority if (chroma_blue < SAMPLE_LOW) begin
      cb_clamp = SAMPLE_LOW;
    end else if (chroma_blue > SAMPLE_HIGH) begin
      cb_clamp = SAMPLE_HIGH;
    end else begin
      cb_clamp = chroma_blue;
    end
    priority if (chroma_red < SAMPLE_LOW) begin
      cr_clamp = SAMPLE_LOW;
    end else if (chroma_red > SAMPLE_HIGH) begin
      cr_clamp = SAMPLE_HIGH;
    end else begin
      cr_clamp = chroma_red;
    end
  end

  assign cb_offs = $signed({1'b0, cb_clamp}) - CHROMA_ZERO;
  assign cr_offs = $signed({1'b0, cr_clamp}) - CHROMA_ZERO;
  assign cb_ext  = TERM_W'(cb_offs);
  assign cr_ext  = TERM_W'(cr_offs);

  assign terms.red   = cr_ext * RED_FROM_CR;
  assign terms.green = (cr_ext * GREEN_FROM_CR) + (cb_ext * GREEN_FROM_CB);
  assign terms.blue  = cb_ext * BLUE_FROM_CB;

endmodule

`default_nettype wire

// ----- hdl/yuv2rgb_pixel.sv -----
// ----------------------------------------------------------------------------
// yuv2rgb_pixel
// Luma term of one pixel, channel sums and saturation to 0..255
// ----------------------------------------------------------------------------
`default_nettype none

module yuv2rgb_pixel (
  input  wire logic [7:0]                 luma,
  input  wire yuv2rgb_pkg::chroma_terms_t terms,
  output yuv2rgb_pkg::pixel_t             rgb
);
  import yuv2rgb_pkg::*;

  logic [SAMPLE_W-1:0]     luma_offs;
  logic [LUMA_W-1:0]       luma_term;
  logic signed [SUM_W-1:0] luma_ext;

  function automatic logic [SAMPLE_W-1:0] saturate(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-9:0] q;
    q = sum[SUM_W-1:8];
    if (sum[SUM_W-1]) begin
      return '0;
    end else if (q > (SUM_W-8)'(CHANNEL_MAX)) begin
      return CHANNEL_MAX;
    end else begin
      return q[SAMPLE_W-1:0];
    end
  endfunction

  always_comb begin
    priority if (luma < SAMPLE_LOW) begin
      luma_offs = '0;
    end else if (luma > SAMPLE_HIGH) begin
      luma_offs = SAMPLE_HIGH - SAMPLE_LOW;
    end else begin
      luma_offs = luma - SAMPLE_LOW;
    end
  end

  assign luma_term = LUMA_W'(luma_offs) * LUMA_GAIN;
  assign luma_ext  = $signed({2'b00, luma_term});

  assign rgb.red   = saturate(luma_ext + SUM_W'(terms.red));
  assign rgb.green = saturate(luma_ext + SUM_W'(terms.green));
  assign rgb.blue  = saturate(luma_ext + SUM_W'(terms.blue));

endmodule

`default_nettype wire

// ----- hdl/yuv420_block_to_rgb_core.sv -----
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_core
// Converts one 2x2 block of a 4:2:0 picture into four RGB888 pixels
//
// in_data carries four luma bytes and the shared Cb and Cr bytes; out_data
// carries red, green and blue for each of the four pixels (BT.601 integer).
// Both channels are valid/ready; a beat moves at a clock edge with valid and
// ready both high.
// An accepted beat goes into the input register, then, once the result
// register can take it, into the result register that drives out_data.
// Throughput: one block per cycle while out_ready stays high, set by the
// input register feeding the conversion logic and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; in_ready then drops until out_ready.
// Reset (rst_n low, synchronous) empties both registers; only the valid flags are reset.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv420_block_to_rgb_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire yuv2rgb_pkg::in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output yuv2rgb_pkg::out_t      out_data
);
  import yuv2rgb_pkg::*;

  logic          s1_valid_r;
  in_t           s1_data_r;
  logic          out_valid_r;
  out_t          out_data_r;
  logic          s1_adv;
  chroma_terms_t terms;
  pixel_t        px_tl;
  pixel_t        px_tr;
  pixel_t        px_bl;
  pixel_t        px_br;
  out_t          out_data_nxt;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  yuv2rgb_chroma u_chroma (
    .chroma_blue (s1_data_r.chroma_blue),
    .chroma_red  (s1_data_r.chroma_red),
    .terms       (terms)
  );

  yuv2rgb_pixel u_px_tl (.luma(s1_data_r.luma_top_left),     .terms(terms), .rgb(px_tl));
  yuv2rgb_pixel u_px_tr (.luma(s1_data_r.luma_top_right),    .terms(terms), .rgb(px_tr));
  yuv2rgb_pixel u_px_bl (.luma(s1_data_r.luma_bottom_left),  .terms(terms), .rgb(px_bl));
  yuv2rgb_pixel u_px_br (.luma(s1_data_r.luma_bottom_right), .terms(terms), .rgb(px_br));

  always_comb begin
    out_data_nxt.red_top_left       = px_tl.red;
    out_data_nxt.green_top_left     = px_tl.green;
    out_data_nxt.blue_top_left      = px_tl.blue;
    out_data_nxt.red_top_right      = px_tr.red;
    out_data_nxt.green_top_right    = px_tr.green;
    out_data_nxt.blue_top_right     = px_tr.blue;
    out_data_nxt.red_bottom_left    = px_bl.red;
    out_data_nxt.green_bottom_left  = px_bl.green;
    out_data_nxt.blue_bottom_left   = px_bl.blue;
    out_data_nxt.red_bottom_right   = px_br.red;
    out_data_nxt.green_bottom_right = px_br.green;
    out_data_nxt.blue_bottom_right  = px_br.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input stage must hold a beat while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input stage lost a beat while stalled");

  // an empty input stage always takes a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("in_ready low with empty input stage");

  // an accepted beat lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted beat missing from input stage");

  // a beat leaving the input stage shows up as a result
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv |=> out_valid_r)
    else $error("beat from input stage not presented");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4:2:0 2x2 block to RGB888 converter
//
// Directed blocks hit the luma and chroma clamp points, negative channel sums
// and channel overflow. Random blocks follow, with bytes either uniform or
// near the clamp points. Each accepted input beat is converted by an
// independent BT.601 integer conversion and queued. Each output beat is
// checked channel by channel against the oldest queued block. Both sides idle
// at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import yuv2rgb_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_BLOCKS = 1800;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;

  localparam int Y_SCALE    = 298;
  localparam int CR_TO_RED  = 408;
  localparam int CR_TO_GRN  = -208;
  localparam int CB_TO_GRN  = -100;
  localparam int CB_TO_BLUE = 517;
  localparam int CLAMP_LO   = 16;
  localparam int CLAMP_HI   = 240;
  localparam int CHROMA_MID = 128;
  localparam int OUT_W      = $bits(out_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t pending_blocks[$];
  out_t rgb_expected[$];
  int error_count = 0;
  int cycle_count = 0;
  int blocks_issued = 0;
  int results_taken = 0;
  int gap_left = 0;
  int stall_left = 0;
  out_t rgb_want;
  logic [OUT_W-1:0] got_flat;
  logic [OUT_W-1:0] want_flat;

  string rgb_field_names[12] = '{
    "red_top_left", "green_top_left", "blue_top_left",
    "red_top_right", "green_top_right", "blue_top_right",
    "red_bottom_left", "green_bottom_left", "blue_bottom_left",
    "red_bottom_right", "green_bottom_right", "blue_bottom_right"
  };

  yuv420_block_to_rgb_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int chroma_centered(logic [7:0] raw);
    int v;
    v = raw;
    if (v < CLAMP_LO) v = CLAMP_LO;
    if (v > CLAMP_HI) v = CLAMP_HI;
    return v - CHROMA_MID;
  endfunction

  function automatic logic [7:0] clip_channel(int sum);
    int q;
    if (sum < 0) return 8'd0;
    q = sum >>> 8;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic out_t convert_block(in_t blk);
    int cb;
    int cr;
    int red_c;
    int grn_c;
    int blue_c;
    int y;
    int v;
    logic [7:0] luma [4];
    logic [OUT_W-1:0] flat;
    cb = chroma_centered(blk.chroma_blue);
    cr = chroma_centered(blk.chroma_red);
    red_c = CR_TO_RED * cr;
    grn_c = CR_TO_GRN * cr + CB_TO_GRN * cb;
    blue_c = CB_TO_BLUE * cb;
    luma[0] = blk.luma_top_left;
    luma[1] = blk.luma_top_right;
    luma[2] = blk.luma_bottom_left;
    luma[3] = blk.luma_bottom_right;
    flat = '0;
    for (int p = 0; p < 4; p++) begin
      v = luma[p];
      if (v < CLAMP_LO) begin
        y = 0;
      end else begin
        if (v > CLAMP_HI) v = CLAMP_HI;
        y = Y_SCALE * (v - CLAMP_LO);
      end
      flat = {flat[OUT_W-25:0], clip_channel(y + red_c), clip_channel(y + grn_c),
              clip_channel(y + blue_c)};
    end
    return out_t'(flat);
  endfunction

  function automatic int idle_cycles(int n, int period);
    if ((n / period) % 4 == 0) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [7:0] sample_byte();
    logic [7:0] edges [11] = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128, 8'd129,
                               8'd239, 8'd240, 8'd241, 8'd255};
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 255));
    return edges[$urandom_range(0, 10)];
  endfunction

  task automatic add_block(logic [7:0] y0, logic [7:0] y1, logic [7:0] y2,
                           logic [7:0] y3, logic [7:0] cb, logic [7:0] cr);
    in_t blk;
    blk.luma_top_left     = y0;
    blk.luma_top_right    = y1;
    blk.luma_bottom_left  = y2;
    blk.luma_bottom_right = y3;
    blk.chroma_blue       = cb;
    blk.chroma_red        = cr;
    pending_blocks.push_back(blk);
  endtask

  task automatic report_mismatch(string field, int idx, logic [7:0] got,
                                 logic [7:0] want);
    $display("mismatch block %0d %s: got %0d expected %0d", idx, field, got, want);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        rgb_expected.push_back(convert_block(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          in_data <= pending_blocks.pop_front();
          in_valid <= 1'b1;
          gap_left = idle_cycles(blocks_issued, 64);
          blocks_issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rgb_expected.size() == 0) begin
          $display("unexpected beat %0d on out_data", results_taken);
          error_count++;
        end else begin
          rgb_want = rgb_expected.pop_front();
          got_flat = out_data;
          want_flat = rgb_want;
          for (int f = 0; f < 12; f++) begin
            if (got_flat[OUT_W-1-8*f -: 8] !== want_flat[OUT_W-1-8*f -: 8]) begin
              report_mismatch(rgb_field_names[f], results_taken,
                              got_flat[OUT_W-1-8*f -: 8], want_flat[OUT_W-1-8*f -: 8]);
            end
          end
        end
        results_taken++;
        stall_left = idle_cycles(results_taken, 47);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    add_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_block(8'd15, 8'd16, 8'd17, 8'd240, 8'd128, 8'd128);
    add_block(8'd241, 8'd255, 8'd0, 8'd128, 8'd128, 8'd128);
    add_block(8'd16, 8'd128, 8'd235, 8'd255, 8'd15, 8'd15);
    add_block(8'd16, 8'd128, 8'd235, 8'd255, 8'd16, 8'd16);
    add_block(8'd16, 8'd128, 8'd235, 8'd255, 8'd240, 8'd240);
    add_block(8'd16, 8'd128, 8'd235, 8'd255, 8'd241, 8'd241);
    add_block(8'd60, 8'd120, 8'd180, 8'd230, 8'd0, 8'd255);
    add_block(8'd60, 8'd120, 8'd180, 8'd230, 8'd255, 8'd0);
    add_block(8'd16, 8'd0, 8'd30, 8'd16, 8'd128, 8'd16);
    add_block(8'd255, 8'd240, 8'd200, 8'd241, 8'd255, 8'd128);
    add_block(8'd240, 8'd241, 8'd255, 8'd220, 8'd128, 8'd240);
    add_block(8'd20, 8'd16, 8'd0, 8'd40, 8'd240, 8'd240);
    add_block(8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h55, 8'hAA);
    add_block(8'hAA, 8'h55, 8'hF0, 8'h0F, 8'hAA, 8'h55);
    add_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
    add_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd16, 8'd240);
    add_block(8'd1, 8'd2, 8'd4, 8'd8, 8'd32, 8'd64);
    add_block(8'd16, 8'd17, 8'd239, 8'd240, 8'd240, 8'd16);
    for (int i = 0; i < RANDOM_BLOCKS; i++) begin
      add_block(sample_byte(), sample_byte(), sample_byte(), sample_byte(),
                sample_byte(), sample_byte());
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_blocks.size() > 0 || in_valid) @(posedge clk);
    while (rgb_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
